// ===== src/pbts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pbts_pkg;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_TICK    = 3'd1,
    OP_DELAY   = 3'd2,
    OP_LOCK    = 3'd3,
    OP_UNLOCK  = 3'd4,
    OP_START   = 3'd5,
    OP_RESCHED = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_WALK,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic apply;
    logic walk;
    logic scan;
    logic decide;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_tick;
    logic walk_done;
    logic scan_done;
    logic out_busy;
  } sts_t;

  localparam logic [7:0] LOCK_MAX = 8'd255;

  // ready bits examined per scan cycle
  localparam int CHUNK_W   = 8;
  localparam int CHUNK_IDX = 3;

  function automatic logic [CHUNK_IDX-1:0] lowest_set8(input logic [CHUNK_W-1:0] bits);
    logic [CHUNK_IDX-1:0] idx;
    idx = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = CHUNK_IDX'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== src/priority_bitmap_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// priority bitmap task scheduler, one task per priority, lower number more urgent
// input channel s_*: one item per operating system event (create, tick, delay,
//   lock, unlock, start, reschedule); every item yields exactly one result item
// output channel m_*: switch request, target task, any-ready flag, lock depth
// one item is worked at a time; s_tready is high only while the controller idles
// steps from accept to result valid:
//   tick: a walk over the delay counter memory (one counter read and one written
//     per cycle), then the scan of the ready mask
//   other operations: the apply step, then the scan of the ready mask, eight
//     bits per cycle, stopping at the first set bit
// results sit in an output register, so a new item is taken while the last
//   result waits; when the receiver stalls, the next result waits inside the
//   block and input stops after that item
// reset clears the ready and delayed masks, lock depth and current task; the
//   delay counters are not cleared, only counters of delayed tasks are used
module priority_bitmap_task_scheduler #(
  parameter int PRIO_COUNT = 32,
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // operation[2:0], task_prio[7:3], delay_ticks[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // switch_request[0], next_task[5:1], ready_any[6],
                                 // lock_level[14:7], zero[15]
);
  import pbts_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       switch_request;
  logic [4:0] next_task;
  logic       ready_any;
  logic [7:0] lock_level;

  pbts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  pbts_datapath #(
    .PRIO_COUNT (PRIO_COUNT),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (s_tdata[2:0]),
    .in_task_prio       (s_tdata[7:3]),
    .in_delay_ticks     (s_tdata[39:8]),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_switch_request (switch_request),
    .out_next_task      (next_task),
    .out_ready_any      (ready_any),
    .out_lock_level     (lock_level)
  );

  // pack result fields, lowest field in the lowest bits
  assign m_tdata = {1'b0, lock_level, ready_any, next_task, switch_request};

endmodule

`default_nettype wire

// ===== src/pbts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  pbts_pkg::sts_t sts,
  output pbts_pkg::cmd_t cmd
);
  import pbts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_is_tick ? ST_WALK : ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // wait until the output register can take the result
        if (!sts.out_busy) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/pbts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbts_datapath #(
  parameter int PRIO_COUNT = 32,
  parameter int TICK_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  pbts_pkg::cmd_t cmd,
  output pbts_pkg::sts_t sts,
  input  logic [2:0]     in_operation,
  input  logic [4:0]     in_task_prio,
  input  logic [31:0]    in_delay_ticks,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_switch_request,
  output logic [4:0]     out_next_task,
  output logic           out_ready_any,
  output logic [7:0]     out_lock_level
);
  import pbts_pkg::*;

  localparam int PRIO_W = $clog2(PRIO_COUNT);
  localparam int NCHUNK = (PRIO_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int IDX_W  = CW + CHUNK_IDX;
  localparam int SCAN_W = NCHUNK * CHUNK_W;

  // item registers
  op_t                   op;
  logic [4:0]            prio;
  logic [TICK_WIDTH-1:0] ticks;

  // scheduler state
  logic [PRIO_COUNT-1:0] ready_mask;
  logic [PRIO_COUNT-1:0] delayed_mask;
  logic [7:0]            lock;
  logic [IDX_W-1:0]      cur;
  logic                  cur_valid;
  logic                  do_resched;

  // delay counters
  logic [TICK_WIDTH-1:0] mem [PRIO_COUNT];
  logic [PRIO_W:0]       walk_cnt;
  logic                  rd_valid;
  logic [PRIO_W-1:0]     rd_addr;
  logic [TICK_WIDTH-1:0] rd_data;

  // ready scan
  logic [CW-1:0]         chunk;
  logic                  found;
  logic [IDX_W-1:0]      best;

  logic [31:0]           prio_ext;
  logic                  prio_ok;
  logic [PRIO_W-1:0]     prio_idx;
  logic [PRIO_W-1:0]     cur_addr;
  logic [TICK_WIDTH-1:0] dec;
  logic                  walk_hit;
  logic [TICK_WIDTH-1:0] delay_val;
  logic                  we;
  logic [PRIO_W-1:0]     wa;
  logic [TICK_WIDTH-1:0] wd;
  logic                  walk_done;
  logic [SCAN_W-1:0]     padded;
  logic [CHUNK_W-1:0]    chunk_bits;
  logic                  hit;
  logic                  last;
  logic                  sw;
  logic                  take;
  logic [IDX_W-1:0]      target;
  logic [IDX_W-1:0]      next_idx;
  logic [IDX_W+4:0]      next_ext;

  assign prio_ext  = 32'(prio);
  assign prio_ok   = prio_ext < 32'(PRIO_COUNT);
  assign prio_idx  = prio_ext[PRIO_W-1:0];
  assign cur_addr  = cur[PRIO_W-1:0];
  assign dec       = rd_data - TICK_WIDTH'(1);
  assign walk_hit  = rd_valid && delayed_mask[rd_addr];
  assign delay_val = (ticks == '0) ? TICK_WIDTH'(1) : ticks;
  assign walk_done = walk_cnt == (PRIO_W + 1)'(PRIO_COUNT);

  // write port shared by the tick walk and the delay operation
  assign we = walk_hit || (cmd.apply && op == OP_DELAY && cur_valid);
  assign wa = walk_hit ? rd_addr : cur_addr;
  assign wd = walk_hit ? dec : delay_val;

  assign padded     = SCAN_W'(ready_mask);
  assign chunk_bits = padded[chunk * CHUNK_W +: CHUNK_W];
  assign hit        = |chunk_bits;
  assign last       = chunk == CW'(NCHUNK - 1);

  assign sts.in_is_tick = in_operation == OP_TICK;
  assign sts.walk_done  = walk_done;
  assign sts.scan_done  = hit || last;
  assign sts.out_busy   = out_valid && !out_ready;

  always_comb begin
    sw     = 1'b0;
    take   = 1'b0;
    target = best;
    if (do_resched) begin
      if (lock == '0 && found && !(cur_valid && cur == best)) begin
        sw   = 1'b1;
        take = 1'b1;
      end
    end else if (op == OP_START) begin
      if (cur_valid) begin
        sw     = 1'b1;
        target = cur;
      end else if (found) begin
        sw   = 1'b1;
        take = 1'b1;
      end
    end
  end

  assign next_idx = sw ? target : (found ? best : '0);
  assign next_ext = (IDX_W + 5)'(next_idx);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[walk_cnt[PRIO_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_mask   <= '0;
      delayed_mask <= '0;
      lock         <= '0;
      cur          <= '0;
      cur_valid    <= 1'b0;
      do_resched   <= 1'b0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.load) begin
        op         <= op_t'(in_operation);
        prio       <= in_task_prio;
        ticks      <= in_delay_ticks[TICK_WIDTH-1:0];
        do_resched <= in_operation == OP_TICK || in_operation == OP_DELAY ||
                      in_operation == OP_RESCHED;
        walk_cnt   <= '0;
        chunk      <= '0;
        found      <= 1'b0;
      end

      if (cmd.apply) begin
        case (op)
          OP_CREATE: begin
            if (prio_ok) begin
              ready_mask[prio_idx]   <= 1'b1;
              delayed_mask[prio_idx] <= 1'b0;
            end
          end
          OP_DELAY: begin
            if (cur_valid) begin
              delayed_mask[cur_addr] <= 1'b1;
              ready_mask[cur_addr]   <= 1'b0;
            end
          end
          OP_LOCK: begin
            if (lock != LOCK_MAX) begin
              lock <= lock + 8'd1;
            end
          end
          OP_UNLOCK: begin
            if (lock != '0) begin
              lock       <= lock - 8'd1;
              do_resched <= lock == 8'd1;
            end
          end
          default: begin
          end
        endcase
      end

      // read one counter per cycle, write back the decrement in the next cycle
      rd_valid <= cmd.walk && !walk_done;
      if (cmd.walk && !walk_done) begin
        rd_addr  <= walk_cnt[PRIO_W-1:0];
        walk_cnt <= walk_cnt + 1'b1;
      end
      if (walk_hit && dec == '0) begin
        delayed_mask[rd_addr] <= 1'b0;
        ready_mask[rd_addr]   <= 1'b1;
      end

      if (cmd.scan && !found) begin
        if (!last) begin
          chunk <= chunk + 1'b1;
        end
        if (hit) begin
          found <= 1'b1;
          best  <= {chunk, lowest_set8(chunk_bits)};
        end
      end

      if (cmd.decide) begin
        if (take) begin
          cur       <= best;
          cur_valid <= 1'b1;
        end
        out_switch_request <= sw;
        out_next_task      <= next_ext[4:0];
        out_ready_any      <= found;
        out_lock_level     <= lock;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pbts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pbts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // one item at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted back to back");

  // the fill bit above the lock level stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[15])
    else $error("fill bit set in result");

  // without a ready task and without a switch the target reads zero
  a_idle_target_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[6] && !m_tdata[0]) |-> (m_tdata[5:1] == 5'd0))
    else $error("nonzero target with no ready task");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind priority_bitmap_task_scheduler pbts_checker u_pbts_checker (.*);

`default_nettype wire

// ===== test/priority_bitmap_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module priority_bitmap_task_scheduler_tb;
  import pbts_pkg::*;

  localparam int TASKS          = 32;
  localparam int RESET_CYCLES   = 12;
  localparam int STALL_LIMIT    = 4000;  // cycles with no item moving on either side
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 80;    // longer than a tick walk plus the ready scan

  // result item as it sits on m_tdata, lowest bit last
  typedef struct packed {
    logic       pad;
    logic [7:0] lock_level;
    logic       ready_any;
    logic [4:0] next_task;
    logic       switch_request;
  } sched_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  priority_bitmap_task_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // scheduler state as predicted by the testbench
  logic [31:0] ready_bits;
  logic [31:0] delayed_bits;
  logic [31:0] wake_count [TASKS];
  logic [4:0]  running_task;
  logic        running_valid;
  logic [7:0]  lock_nest;

  sched_result_t pending_decisions [$];
  int          errors       = 0;
  int          src_idle_pct = 0;
  int          rx_idle_pct  = 0;
  logic        rx_hold_start = 1'b0;
  int          rx_hold_left  = 0;

  // {found, index} of the most urgent ready task
  function automatic logic [5:0] most_urgent_ready();
    logic [5:0] found;
    found = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (ready_bits[i]) begin
        found = {1'b1, 5'(i)};
      end
    end
    return found;
  endfunction

  function automatic logic try_switch(output logic [4:0] target);
    logic [5:0] best;
    best   = most_urgent_ready();
    target = '0;
    if (lock_nest != 8'd0 || !best[5]) return 1'b0;
    if (running_valid && running_task == best[4:0]) return 1'b0;
    running_task  = best[4:0];
    running_valid = 1'b1;
    target        = best[4:0];
    return 1'b1;
  endfunction

  function automatic sched_result_t schedule_event(input op_t op, input logic [4:0] prio,
                                                   input logic [31:0] ticks);
    sched_result_t res;
    logic          sw;
    logic [4:0]    target;
    logic [5:0]    best;
    sw     = 1'b0;
    target = '0;
    case (op)
      OP_CREATE: begin
        ready_bits[prio]   = 1'b1;
        delayed_bits[prio] = 1'b0;
      end
      OP_TICK: begin
        for (int i = 0; i < TASKS; i++) begin
          if (delayed_bits[i]) begin
            wake_count[i] = wake_count[i] - 32'd1;
            if (wake_count[i] == 32'd0) begin
              delayed_bits[i] = 1'b0;
              ready_bits[i]   = 1'b1;
            end
          end
        end
        sw = try_switch(target);
      end
      OP_DELAY: begin
        if (running_valid) begin
          wake_count[running_task]   = (ticks == 32'd0) ? 32'd1 : ticks;
          delayed_bits[running_task] = 1'b1;
          ready_bits[running_task]   = 1'b0;
        end
        sw = try_switch(target);
      end
      OP_LOCK: begin
        if (lock_nest != LOCK_MAX) lock_nest = lock_nest + 8'd1;
      end
      OP_UNLOCK: begin
        if (lock_nest != 8'd0) begin
          lock_nest = lock_nest - 8'd1;
          if (lock_nest == 8'd0) sw = try_switch(target);
        end
      end
      OP_START: begin
        // start ignores the lock
        if (running_valid) begin
          target = running_task;
          sw     = 1'b1;
        end else begin
          best = most_urgent_ready();
          if (best[5]) begin
            running_task  = best[4:0];
            running_valid = 1'b1;
            target        = best[4:0];
            sw            = 1'b1;
          end
        end
      end
      OP_RESCHED: sw = try_switch(target);
      default: ;
    endcase
    best               = most_urgent_ready();
    res.pad            = 1'b0;
    res.switch_request = sw;
    res.next_task      = sw ? target : best[4:0];
    res.ready_any      = best[5];
    res.lock_level     = lock_nest;
    return res;
  endfunction

  // offer one item, idling first at the current sender rate; valid stays high after accept
  task automatic send_item(input op_t op, input logic [4:0] prio, input logic [31:0] ticks);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ticks, prio, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_decisions.push_back(schedule_event(op, prio, ticks));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  function automatic logic [4:0] any_prio();
    return 5'($urandom_range(31));
  endfunction

  task automatic test_directed_cases();
    send_item(OP_RESCHED, any_prio(), $urandom);     // nothing ready, no switch
    send_item(OP_START,   any_prio(), $urandom);     // start with nothing ready
    send_item(OP_DELAY,   any_prio(), 32'd5);        // delay with no running task
    send_item(OP_TICK,    any_prio(), $urandom);
    send_item(OP_UNLOCK,  any_prio(), $urandom);     // unlock at zero is ignored
    send_item(OP_CREATE,  5'd31, 32'hffff_ffff);
    send_item(OP_START,   5'd0, 32'd0);              // first start picks task 31
    send_item(OP_CREATE,  5'd5, $urandom);
    send_item(OP_RESCHED, any_prio(), $urandom);
    send_item(OP_LOCK,    any_prio(), $urandom);
    send_item(OP_CREATE,  5'd0, $urandom);
    send_item(OP_RESCHED, any_prio(), $urandom);     // locked, no switch
    send_item(OP_START,   any_prio(), $urandom);     // start with a running task
    send_item(OP_UNLOCK,  any_prio(), $urandom);     // back to zero, reschedules to 0
    send_item(OP_DELAY,   any_prio(), 32'd0);        // zero delay counts as one tick
    send_item(OP_TICK,    any_prio(), $urandom);     // task 0 wakes again
    send_item(OP_DELAY,   any_prio(), 32'hffff_ffff);
    send_item(OP_TICK,    any_prio(), $urandom);
    send_item(OP_CREATE,  5'd0, $urandom);           // create of a delayed task
    send_item(OP_RESCHED, any_prio(), $urandom);
    send_item(OP_DELAY,   any_prio(), 32'd2);
    send_item(OP_TICK,    any_prio(), $urandom);
    send_item(OP_TICK,    any_prio(), $urandom);
  endtask

  // lock depth saturates at the maximum and unwinds to zero
  task automatic test_lock_saturation();
    for (int i = 0; i < 258; i++) send_item(OP_LOCK, any_prio(), $urandom);
    send_item(OP_RESCHED, any_prio(), $urandom);
    for (int i = 0; i < 257; i++) send_item(OP_UNLOCK, any_prio(), $urandom);
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits it out
  task automatic test_backpressure();
    int saved_src;
    saved_src     = src_idle_pct;
    src_idle_pct  = 0;
    rx_hold_start = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 0) ? OP_TICK : OP_CREATE, any_prio(), $urandom);
    end
    wait_for_results();
    src_idle_pct = saved_src;
  endtask

  task automatic test_random_traffic(input int count);
    int          pick;
    logic [31:0] ticks;
    op_t         op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 15)      op = OP_CREATE;
      else if (pick < 45) op = OP_TICK;
      else if (pick < 60) op = OP_DELAY;
      else if (pick < 70) op = OP_LOCK;
      else if (pick < 82) op = OP_UNLOCK;
      else if (pick < 88) op = OP_START;
      else                op = OP_RESCHED;
      // mostly short delays so tasks come back, now and then a huge one
      pick = $urandom_range(9);
      if (pick < 7)       ticks = 32'($urandom_range(6, 1));
      else if (pick == 7) ticks = 32'd0;
      else if (pick == 8) ticks = 32'($urandom_range(40, 7));
      else                ticks = $urandom;
      send_item(op, any_prio(), ticks);
    end
  endtask

  // receiver: random ready, or a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_start) begin
      rx_hold_start = 1'b0;
      rx_hold_left  = RX_HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    sched_result_t want;
    sched_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none actual %0h", $time, m_tdata);
      end else begin
        want = pending_decisions.pop_front();
        check_field("switch_request", 8'(want.switch_request), 8'(got.switch_request));
        check_field("next_task", 8'(want.next_task), 8'(got.next_task));
        check_field("ready_any", 8'(want.ready_any), 8'(got.ready_any));
        check_field("lock_level", want.lock_level, got.lock_level);
        check_field("pad", 8'(want.pad), 8'(got.pad));
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    ready_bits    = '0;
    delayed_bits  = '0;
    running_task  = '0;
    running_valid = 1'b0;
    lock_nest     = '0;
    for (int i = 0; i < TASKS; i++) wake_count[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // slow receiver
    src_idle_pct = 9;
    rx_idle_pct  = 75;
    test_directed_cases();
    test_lock_saturation();
    test_random_traffic(110);

    // slow sender
    src_idle_pct = 75;
    rx_idle_pct  = 9;
    test_backpressure();
    test_random_traffic(110);

    // full rate
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    test_random_traffic(110);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_decisions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
